### design/psu_pkg.sv
// Shared types, constants and lookup functions for the particle state update block.
`default_nettype none
package psu_pkg;

  localparam int unsigned VecW   = 22;   // Q13.8 position and velocity
  localparam int unsigned RampW  = 12;   // Q4.8 ramp position
  localparam int unsigned TimeW  = 32;   // Q16.16 time
  localparam int unsigned StepW  = 16;   // Q0.16 frame step
  localparam int unsigned ColorW = 8;
  localparam int unsigned AlphaW = 8;
  localparam int unsigned GravW  = 14;   // (step*40)>>8 fits here
  localparam int unsigned SumW   = 27;   // wide sums before saturation
  localparam int unsigned ProdW  = VecW + StepW + 1;

  localparam logic [RampW:0]   FireLimit   = 13'd1536;  // 6.0 in Q4.8
  localparam logic [RampW:0]   ExplLimit   = 13'd2048;  // 8.0 in Q4.8
  localparam logic [RampW-1:0] RampTop     = 12'hFFF;
  localparam logic [AlphaW-1:0] AlphaOpaque = 8'hFF;

  localparam logic signed [SumW-1:0] VecMin = -27'sd2097152;
  localparam logic signed [SumW-1:0] VecMax = 27'sd2097151;

  // cfg register indexes
  localparam logic RegNowTime   = 1'b0;
  localparam logic RegFrameStep = 1'b1;

  typedef enum logic [2:0] {
    KIND_STATIC   = 3'd0,
    KIND_GRAV     = 3'd1,
    KIND_SLOWGRAV = 3'd2,
    KIND_FIRE     = 3'd3,
    KIND_EXPLODE  = 3'd4,
    KIND_EXPLODE2 = 3'd5,
    KIND_BLOB     = 3'd6,
    KIND_BLOB2    = 3'd7
  } kind_t;

  // velocity term applied to one axis
  typedef enum logic [1:0] {
    TERM_NONE,
    TERM_ADD_GROWTH,
    TERM_SUB_GROWTH,
    TERM_SUB_DAMP
  } term_op_t;

  typedef enum logic [1:0] {
    GRAV_NONE,
    GRAV_SUB,
    GRAV_ADD
  } grav_op_t;

  typedef struct packed {
    term_op_t term;
    grav_op_t grav;
  } axis_ctl_t;

  typedef struct packed {
    logic [TimeW-1:0] now_time;
    logic [StepW-1:0] frame_step;
  } cfg_t;

  function automatic logic [ColorW-1:0] ramp1_lut(input logic [2:0] idx);
    logic [ColorW-1:0] c;
    case (idx)
      3'd0: c = 8'h6f;
      3'd1: c = 8'h6d;
      3'd2: c = 8'h6b;
      3'd3: c = 8'h69;
      3'd4: c = 8'h67;
      3'd5: c = 8'h65;
      3'd6: c = 8'h63;
      default: c = 8'h61;
    endcase
    return c;
  endfunction

  function automatic logic [ColorW-1:0] ramp2_lut(input logic [2:0] idx);
    logic [ColorW-1:0] c;
    case (idx)
      3'd0: c = 8'h6f;
      3'd1: c = 8'h6e;
      3'd2: c = 8'h6d;
      3'd3: c = 8'h6c;
      3'd4: c = 8'h6b;
      3'd5: c = 8'h6a;
      3'd6: c = 8'h68;
      default: c = 8'h66;
    endcase
    return c;
  endfunction

  function automatic logic [ColorW-1:0] ramp3_lut(input logic [2:0] idx);
    logic [ColorW-1:0] c;
    case (idx)
      3'd0: c = 8'h6d;
      3'd1: c = 8'h6b;
      3'd2: c = 8'h06;
      3'd3: c = 8'h05;
      3'd4: c = 8'h04;
      3'd5: c = 8'h03;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic signed [VecW-1:0] sat_vec(input logic signed [SumW-1:0] v);
    logic signed [VecW-1:0] r;
    if (v < VecMin) begin
      r = VecMin[VecW-1:0];
    end else if (v > VecMax) begin
      r = VecMax[VecW-1:0];
    end else begin
      r = v[VecW-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### design/particle_state_update.sv
// Top level: particle record stream in, updated particle record stream out.
//
//  channel | dir | width         | contents
//  in_     | in  | 184 + 3 user  | particle record; tuser = kind
//  out_    | out | 192 + 1 user  | updated record; tuser = alive
//  cfg_    | in  | 32 data, 3 a  | now_time @0x0, frame_step @0x4
//
// One word per cycle sustained while out_tready stays high; a word passes the input
// register, then the result register, with the single 22x17 multiply per axis between them.
// Reset (rst_n low, synchronous) clears both stage valids and the cfg registers.
// A stall on out_tready holds the result register; the input register still
// fills behind it, and in_tready drops only when both stages are full.
`default_nettype none
module particle_state_update (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // pos_x[21:0] pos_y[43:22] pos_z[65:44] vel_x[87:66] vel_y[109:88]
  // vel_z[131:110] ramp[143:132] die_time[175:144] color[183:176]
  input  wire logic [183:0] in_tdata,
  // kind[2:0]
  input  wire logic [2:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // new_pos_x[21:0] new_pos_y[43:22] new_pos_z[65:44] new_vel_x[87:66]
  // new_vel_y[109:88] new_vel_z[131:110] new_ramp[143:132]
  // new_color[151:144] new_die_time[183:152] alpha[191:184]
  output logic [191:0]      out_tdata,
  // alive[0]
  output logic [0:0]        out_tuser,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  psu_pkg::cfg_t cfg;

  // input stage
  logic           in_v_r;
  logic [183:0]   in_data_r;
  psu_pkg::kind_t in_kind_r;

  // result stage
  logic           out_v_r;
  logic [191:0]   out_data_r;
  logic           out_alive_r;

  logic           adv;          // result register may take a new word
  logic [191:0]   res_data_nxt;
  logic           res_alive_nxt;

  logic signed [psu_pkg::VecW-1:0] pos [3];
  logic signed [psu_pkg::VecW-1:0] vel [3];
  logic signed [psu_pkg::VecW-1:0] npos [3];
  logic signed [psu_pkg::VecW-1:0] nvel [3];
  psu_pkg::axis_ctl_t              ctl [3];

  logic [psu_pkg::RampW-1:0]  ramp;
  logic [psu_pkg::TimeW-1:0]  die_time;
  logic [psu_pkg::ColorW-1:0] color;
  logic [psu_pkg::RampW-1:0]  new_ramp;
  logic [psu_pkg::ColorW-1:0] new_color;
  logic [psu_pkg::TimeW-1:0]  new_die_time;
  logic [psu_pkg::AlphaW-1:0] alpha;
  logic [21:0]                step40;
  logic [psu_pkg::GravW-1:0]  grav;
  logic                       dead;

  psu_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Handshake: a word moves into the result register whenever it is empty or
  // being drained; the input register refills in the same cycle.
  assign adv       = !out_v_r || out_tready;
  assign in_tready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
      in_kind_r <= psu_pkg::kind_t'(in_tuser);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_v_r) begin
      out_data_r  <= res_data_nxt;
      out_alive_r <= res_alive_nxt;
    end
  end

  // Unpack the held record.
  assign pos[0]   = in_data_r[21:0];
  assign pos[1]   = in_data_r[43:22];
  assign pos[2]   = in_data_r[65:44];
  assign vel[0]   = in_data_r[87:66];
  assign vel[1]   = in_data_r[109:88];
  assign vel[2]   = in_data_r[131:110];
  assign ramp     = in_data_r[143:132];
  assign die_time = in_data_r[175:144];
  assign color    = in_data_r[183:176];

  // grav = (step*40)>>8, built from shifts
  assign step40 = ({6'd0, cfg.frame_step} << 5) + ({6'd0, cfg.frame_step} << 3);
  assign grav   = step40[21:8];

  // Per-kind velocity rules; z alone carries gravity.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ctl[i].term = psu_pkg::TERM_NONE;
      ctl[i].grav = psu_pkg::GRAV_NONE;
    end
    case (in_kind_r)
      psu_pkg::KIND_GRAV, psu_pkg::KIND_SLOWGRAV: begin
        ctl[2].grav = psu_pkg::GRAV_SUB;
      end
      psu_pkg::KIND_FIRE: begin
        ctl[2].grav = psu_pkg::GRAV_ADD;
      end
      psu_pkg::KIND_EXPLODE, psu_pkg::KIND_BLOB: begin
        for (int i = 0; i < 3; i++) ctl[i].term = psu_pkg::TERM_ADD_GROWTH;
        ctl[2].grav = psu_pkg::GRAV_SUB;
      end
      psu_pkg::KIND_EXPLODE2: begin
        for (int i = 0; i < 3; i++) ctl[i].term = psu_pkg::TERM_SUB_DAMP;
        ctl[2].grav = psu_pkg::GRAV_SUB;
      end
      psu_pkg::KIND_BLOB2: begin
        ctl[0].term = psu_pkg::TERM_SUB_GROWTH;
        ctl[1].term = psu_pkg::TERM_SUB_GROWTH;
        ctl[2].grav = psu_pkg::GRAV_SUB;
      end
      default: ;
    endcase
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    psu_axis u_axis (
      .pos        (pos[a]),
      .vel        (vel[a]),
      .frame_step (cfg.frame_step),
      .grav       (grav),
      .ctl        (ctl[a]),
      .new_pos    (npos[a]),
      .new_vel    (nvel[a])
    );
  end

  psu_ramp u_ramp (
    .ramp         (ramp),
    .kind         (in_kind_r),
    .frame_step   (cfg.frame_step),
    .die_time     (die_time),
    .color        (color),
    .new_ramp     (new_ramp),
    .new_color    (new_color),
    .new_die_time (new_die_time),
    .alpha        (alpha)
  );

  // Expired particle: drop all fields to zero and flag it dead.
  assign dead = die_time < cfg.now_time;

  always_comb begin
    if (dead) begin
      res_data_nxt  = '0;
      res_alive_nxt = 1'b0;
    end else begin
      res_data_nxt  = {alpha, new_die_time, new_color, new_ramp,
                       nvel[2], nvel[1], nvel[0], npos[2], npos[1], npos[0]};
      res_alive_nxt = 1'b1;
    end
  end

  assign out_tvalid   = out_v_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_alive_r;

endmodule
`default_nettype wire

### design/psu_cfg_regs.sv
// Configuration registers behind the APB-style port.
`default_nettype none
module psu_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [2:0]                 cfg_paddr,
  input  wire logic [31:0]                cfg_pwdata,
  output logic      [31:0]                cfg_prdata,
  output logic                            cfg_pready,
  output psu_pkg::cfg_t                   cfg
);

  logic [psu_pkg::TimeW-1:0] now_time_r;
  logic [psu_pkg::StepW-1:0] frame_step_r;
  logic                      wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_time_r   <= '0;
      frame_step_r <= '0;
    end else if (wr_en) begin
      case (cfg_paddr[2])
        psu_pkg::RegNowTime:   now_time_r   <= cfg_pwdata;
        psu_pkg::RegFrameStep: frame_step_r <= cfg_pwdata[psu_pkg::StepW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      psu_pkg::RegNowTime:   cfg_prdata = now_time_r;
      psu_pkg::RegFrameStep: cfg_prdata = {16'd0, frame_step_r};
      default:               cfg_prdata = '0;
    endcase
  end

  assign cfg.now_time   = now_time_r;
  assign cfg.frame_step = frame_step_r;

endmodule
`default_nettype wire

### design/psu_axis.sv
// One axis: move position by velocity*step, apply velocity term and gravity, saturate.
`default_nettype none
module psu_axis (
  input  wire logic signed [psu_pkg::VecW-1:0]  pos,
  input  wire logic signed [psu_pkg::VecW-1:0]  vel,
  input  wire logic        [psu_pkg::StepW-1:0] frame_step,
  input  wire logic        [psu_pkg::GravW-1:0] grav,
  input  wire psu_pkg::axis_ctl_t               ctl,
  output logic signed      [psu_pkg::VecW-1:0]  new_pos,
  output logic signed      [psu_pkg::VecW-1:0]  new_vel
);

  logic signed [psu_pkg::StepW:0]     step_s;
  logic signed [psu_pkg::ProdW-1:0]   prod;
  logic signed [psu_pkg::SumW-1:0]    move;     // floor(v*st / 2^16)
  logic signed [psu_pkg::SumW-1:0]    growth;   // floor(4*v*st / 2^16)
  logic signed [psu_pkg::SumW-1:0]    term;
  logic signed [psu_pkg::SumW-1:0]    gterm;
  logic signed [psu_pkg::SumW-1:0]    pos_sum;
  logic signed [psu_pkg::SumW-1:0]    vel_sum;

  assign step_s = signed'({1'b0, frame_step});
  assign prod   = psu_pkg::ProdW'(vel) * psu_pkg::ProdW'(step_s);

  // arithmetic shift floors toward minus infinity
  assign move   = psu_pkg::SumW'(signed'(prod[psu_pkg::ProdW-1:16]));
  assign growth = psu_pkg::SumW'(signed'(prod[psu_pkg::ProdW-1:14]));

  always_comb begin
    case (ctl.term)
      psu_pkg::TERM_ADD_GROWTH: term = growth;
      psu_pkg::TERM_SUB_GROWTH: term = -growth;
      psu_pkg::TERM_SUB_DAMP:   term = -move;
      default:                  term = '0;
    endcase
  end

  always_comb begin
    case (ctl.grav)
      psu_pkg::GRAV_ADD: gterm = signed'(psu_pkg::SumW'(grav));
      psu_pkg::GRAV_SUB: gterm = -signed'(psu_pkg::SumW'(grav));
      default:           gterm = '0;
    endcase
  end

  assign pos_sum = psu_pkg::SumW'(pos) + move;
  assign vel_sum = psu_pkg::SumW'(vel) + term + gterm;

  assign new_pos = psu_pkg::sat_vec(pos_sum);
  assign new_vel = psu_pkg::sat_vec(vel_sum);

endmodule
`default_nettype wire

### design/psu_ramp.sv
// Ramp advance, color lookup, ramp expiry and fire opacity.
`default_nettype none
module psu_ramp (
  input  wire logic [psu_pkg::RampW-1:0]  ramp,
  input  wire psu_pkg::kind_t             kind,
  input  wire logic [psu_pkg::StepW-1:0]  frame_step,
  input  wire logic [psu_pkg::TimeW-1:0]  die_time,
  input  wire logic [psu_pkg::ColorW-1:0] color,
  output logic      [psu_pkg::RampW-1:0]  new_ramp,
  output logic      [psu_pkg::ColorW-1:0] new_color,
  output logic      [psu_pkg::TimeW-1:0]  new_die_time,
  output logic      [psu_pkg::AlphaW-1:0] alpha
);

  logic [19:0]                 step5, step10, step15;
  logic [psu_pkg::RampW-1:0]   inc;
  logic [psu_pkg::RampW:0]     limit;
  logic [psu_pkg::RampW:0]     sum;
  logic [psu_pkg::ColorW-1:0]  lut_color;
  logic                        ramp_kind;
  logic [10:0]                 fire_left;
  logic [16:0]                 fire_scaled;

  assign step5  = ({4'd0, frame_step} << 2) + {4'd0, frame_step};
  assign step10 = step5 << 1;
  assign step15 = step10 + step5;

  always_comb begin
    ramp_kind = 1'b1;
    inc       = '0;
    limit     = psu_pkg::ExplLimit;
    lut_color = color;
    case (kind)
      psu_pkg::KIND_FIRE: begin
        inc       = {1'b0, step5[18:8]};
        limit     = psu_pkg::FireLimit;
        lut_color = psu_pkg::ramp3_lut(sum[10:8]);
      end
      psu_pkg::KIND_EXPLODE: begin
        inc       = step10[19:8];
        lut_color = psu_pkg::ramp1_lut(sum[10:8]);
      end
      psu_pkg::KIND_EXPLODE2: begin
        inc       = step15[19:8];
        lut_color = psu_pkg::ramp2_lut(sum[10:8]);
      end
      default: ramp_kind = 1'b0;
    endcase
  end

  assign sum = {1'b0, ramp} + {1'b0, inc};

  always_comb begin
    new_ramp     = ramp;
    new_color    = color;
    new_die_time = die_time;
    if (ramp_kind) begin
      new_ramp = sum[psu_pkg::RampW] ? psu_pkg::RampTop : sum[psu_pkg::RampW-1:0];
      if (sum >= limit) begin
        new_die_time = '0;
      end else begin
        new_color = lut_color;
      end
    end
  end

  // 255*(1536-r)/1536 reduces to 85*(1536-r)/512
  assign fire_left   = 11'(psu_pkg::FireLimit - {1'b0, ramp});
  assign fire_scaled = 17'(fire_left) * 17'd85;

  always_comb begin
    if (kind != psu_pkg::KIND_FIRE) begin
      alpha = psu_pkg::AlphaOpaque;
    end else if ({1'b0, ramp} > psu_pkg::FireLimit) begin
      alpha = '0;
    end else begin
      alpha = fire_scaled[16:9];
    end
  end

endmodule
`default_nettype wire

### bench/tb_particle_state_update.sv
// Self-checking testbench for particle_state_update: directed and random particles.
`timescale 1ns / 100ps
module tb_particle_state_update;

  localparam logic [2:0]  NowTimeAddr   = {psu_pkg::RegNowTime, 2'b00};
  localparam logic [2:0]  FrameStepAddr = {psu_pkg::RegFrameStep, 2'b00};
  localparam logic [21:0] VecTop        = 22'h1FFFFF;   // +2097151
  localparam logic [21:0] VecBottom     = 22'h200000;   // -2097152
  localparam int          RandomPerSet  = 138;

  // Color ramps, entry 0 first
  localparam logic [0:7][7:0] ExplodeColors  = {8'h6f, 8'h6d, 8'h6b, 8'h69,
                                                8'h67, 8'h65, 8'h63, 8'h61};
  localparam logic [0:7][7:0] Explode2Colors = {8'h6f, 8'h6e, 8'h6d, 8'h6c,
                                                8'h6b, 8'h6a, 8'h68, 8'h66};
  localparam logic [0:7][7:0] FireColors     = {8'h6d, 8'h6b, 8'h06, 8'h05,
                                                8'h04, 8'h03, 8'h00, 8'h00};

  // One particle word: record on tdata, kind on tuser
  typedef struct packed {
    psu_pkg::kind_t kind;
    logic [183:0]   rec;
  } particle_word_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [183:0] in_tdata = '0;
  logic [2:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [191:0] out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [2:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  // Testbench copy of the two registers
  logic [31:0]  now_shadow = '0;
  logic [15:0]  step_shadow = '0;

  particle_word_t particle_q[$];   // words waiting to be driven
  logic [192:0]   update_q[$];     // predicted {alive, record}, oldest first
  int             errors = 0;

  particle_state_update dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Clamp a wide Q13.8 value into the 22-bit range
  function automatic logic [21:0] clamp_vec(input longint x);
    if (x > 64'sd2097151) return VecTop;
    if (x < -64'sd2097152) return VecBottom;
    return x[21:0];
  endfunction

  // Work out the updated record for one particle under the current register values.
  // Returns {alive, alpha, die_time, color, ramp, vel z/y/x, pos z/y/x}.
  function automatic logic [192:0] predict_update(input psu_pkg::kind_t kind,
                                                  input logic [183:0] rec);
    longint      p [3];
    longint      v [3];
    longint      nv [3];
    longint      step;
    longint      grav;
    longint      inc;
    longint      limit;
    longint      ramp_sum;
    logic [11:0] ramp;
    logic [11:0] nramp;
    logic [31:0] die;
    logic [31:0] ndie;
    logic [7:0]  color;
    logic [7:0]  ncolor;
    logic [7:0]  alpha;
    logic [0:7][7:0] colors;
    ramp = rec[143:132];
    die = rec[175:144];
    color = rec[183:176];
    // expired particles come back as all zeros
    if (die < now_shadow) return '0;

    step = longint'(step_shadow);
    grav = (step * 40) >>> 8;
    nramp = ramp;
    ncolor = color;
    ndie = die;
    alpha = 8'd255;
    inc = 0;
    limit = 0;
    colors = ExplodeColors;

    // move first; arithmetic shift on a signed value is a floor
    for (int i = 0; i < 3; i++) begin
      p[i] = $signed(rec[22*i +: 22]);
      v[i] = $signed(rec[66 + 22*i +: 22]);
      nv[i] = v[i];
      p[i] += (v[i] * step) >>> 16;
    end

    case (kind)
      psu_pkg::KIND_FIRE: begin
        if (ramp <= 12'd1536) alpha = 8'((255 * (1536 - int'(ramp))) / 1536);
        else alpha = 8'd0;
        inc = (step * 5) >>> 8;
        limit = 1536;
        colors = FireColors;
      end
      psu_pkg::KIND_EXPLODE: begin
        inc = (step * 10) >>> 8;
        limit = 2048;
        colors = ExplodeColors;
      end
      psu_pkg::KIND_EXPLODE2: begin
        inc = (step * 15) >>> 8;
        limit = 2048;
        colors = Explode2Colors;
      end
      default: ;
    endcase

    // ramp advance: either a new color or the particle runs out
    if (limit != 0) begin
      ramp_sum = longint'(ramp) + inc;
      nramp = (ramp_sum > 4095) ? 12'hFFF : ramp_sum[11:0];
      if (ramp_sum >= limit) ndie = '0;
      else ncolor = colors[ramp_sum[10:8]];
    end

    case (kind)
      psu_pkg::KIND_GRAV, psu_pkg::KIND_SLOWGRAV: nv[2] -= grav;
      psu_pkg::KIND_FIRE: nv[2] += grav;
      psu_pkg::KIND_EXPLODE, psu_pkg::KIND_BLOB: begin
        for (int i = 0; i < 3; i++) nv[i] += (v[i] * 4 * step) >>> 16;
        nv[2] -= grav;
      end
      psu_pkg::KIND_EXPLODE2: begin
        for (int i = 0; i < 3; i++) nv[i] -= (v[i] * step) >>> 16;
        nv[2] -= grav;
      end
      psu_pkg::KIND_BLOB2: begin
        for (int i = 0; i < 2; i++) nv[i] -= (v[i] * 4 * step) >>> 16;
        nv[2] -= grav;
      end
      default: ;
    endcase

    return {1'b1, alpha, ndie, ncolor, nramp,
            clamp_vec(nv[2]), clamp_vec(nv[1]), clamp_vec(nv[0]),
            clamp_vec(p[2]), clamp_vec(p[1]), clamp_vec(p[0])};
  endfunction

  // Driver: present one word at a time, with a random hold-off after each
  always @(posedge clk) begin : drive
    int gap;
    particle_word_t word;
    bit steady;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap = 0;
      steady = 1'b0;
    end else if (!in_tvalid || in_tready) begin
      // word taken at this edge: predict its update under the current registers
      if (in_tvalid) update_q.push_back(predict_update(psu_pkg::kind_t'(in_tuser), in_tdata));
      if (gap > 0) begin
        gap--;
        in_tvalid <= 1'b0;
      end else if (particle_q.size() > 0) begin
        word = particle_q.pop_front();
        in_tdata <= word.rec;
        in_tuser <= word.kind;
        in_tvalid <= 1'b1;
        // now and then switch between back-to-back words and random gaps
        if ($urandom_range(0, 39) == 0) steady = !steady;
        gap = steady ? 0 : $urandom_range(0, 7);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      errors++;
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
    end
  endtask

  // Monitor: stall at random, compare each accepted word with the oldest prediction
  always @(posedge clk) begin : watch
    int stall;
    logic [192:0] exp_word;
    logic [192:0] got;
    bit steady;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall = 0;
      steady = 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata};
        if (update_q.size() == 0) begin
          errors++;
          $error("result word with no particle outstanding: 0x%0h", got);
        end else begin
          exp_word = update_q.pop_front();
          check_field("alive",        32'(exp_word[192]),     32'(got[192]));
          check_field("new_pos_x",    32'(exp_word[21:0]),    32'(got[21:0]));
          check_field("new_pos_y",    32'(exp_word[43:22]),   32'(got[43:22]));
          check_field("new_pos_z",    32'(exp_word[65:44]),   32'(got[65:44]));
          check_field("new_vel_x",    32'(exp_word[87:66]),   32'(got[87:66]));
          check_field("new_vel_y",    32'(exp_word[109:88]),  32'(got[109:88]));
          check_field("new_vel_z",    32'(exp_word[131:110]), 32'(got[131:110]));
          check_field("new_ramp",     32'(exp_word[143:132]), 32'(got[143:132]));
          check_field("new_color",    32'(exp_word[151:144]), 32'(got[151:144]));
          check_field("new_die_time", exp_word[183:152],      got[183:152]);
          check_field("alpha",        32'(exp_word[191:184]), 32'(got[191:184]));
        end
        if ($urandom_range(0, 39) == 0) steady = !steady;
        stall = steady ? 0 : $urandom_range(0, 7);
      end
      if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // APB write: setup cycle, then access until pready
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == NowTimeAddr) now_shadow = data;
    else step_shadow = data[15:0];
  endtask

  task automatic set_clock(input logic [31:0] now_val, input logic [15:0] step_val);
    write_reg(NowTimeAddr, now_val);
    write_reg(FrameStepAddr, {16'h0, step_val});
  endtask

  // Block until every word is in and every result is back, then let the pipe settle
  task automatic wait_drained();
    while (particle_q.size() != 0 || in_tvalid || update_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_particle(input psu_pkg::kind_t kind,
                              input logic [21:0] px, input logic [21:0] py,
                              input logic [21:0] pz, input logic [21:0] vx,
                              input logic [21:0] vy, input logic [21:0] vz,
                              input logic [11:0] ramp, input logic [31:0] die,
                              input logic [7:0] color);
    particle_word_t w;
    w.kind = kind;
    w.rec = {color, die, ramp, vz, vy, vx, pz, py, px};
    particle_q.push_back(w);
  endtask

  // Mostly modest values, with full-range and extreme values mixed in
  function automatic logic [21:0] rand_vec();
    case ($urandom_range(0, 9))
      0: return VecTop;
      1: return VecBottom;
      2, 3, 4: return 22'($urandom);
      default: return 22'(int'($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  // Ramp values cluster around the run-out points and both ends of the range
  function automatic logic [11:0] rand_ramp();
    case ($urandom_range(0, 7))
      4: return 12'($urandom_range(1400, 1700));
      5: return 12'($urandom_range(1900, 2100));
      6: return 12'($urandom_range(3900, 4095));
      7: return 12'($urandom_range(0, 300));
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  // Mostly live particles, some expired, some expiring exactly now
  function automatic logic [31:0] rand_die();
    case ($urandom_range(0, 9))
      0, 1: return (now_shadow == 0) ? 32'h0 : $urandom_range(0, now_shadow - 1);
      2: return now_shadow;
      3: return $urandom;
      default: return $urandom_range(now_shadow, 32'hFFFF_FFFF);
    endcase
  endfunction

  task automatic add_random(input int count);
    repeat (count) begin
      add_particle(psu_pkg::kind_t'($urandom_range(0, 7)), rand_vec(), rand_vec(),
                   rand_vec(), rand_vec(), rand_vec(), rand_vec(), rand_ramp(),
                   rand_die(), 8'($urandom));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: 100.0 s now, about 1/60 s step
    set_clock(32'h0064_0000, 16'h0444);
    // every kind with ordinary values
    add_particle(psu_pkg::KIND_STATIC, 22'd1000, -22'sd2000, 22'd3000, 22'd500,
                 -22'sd700, 22'd900, 12'd0, 32'h0065_0000, 8'h11);
    add_particle(psu_pkg::KIND_GRAV, 22'd10, 22'd20, 22'd30, 22'd2560, 22'd256,
                 -22'sd256, 12'd100, 32'h0065_0000, 8'h22);
    add_particle(psu_pkg::KIND_SLOWGRAV, -22'sd5, 22'd0, 22'd7, -22'sd2560, 22'd1,
                 22'd0, 12'd200, 32'h0065_0000, 8'h33);
    add_particle(psu_pkg::KIND_FIRE, 22'd0, 22'd0, 22'd0, 22'd300, 22'd300, 22'd300,
                 12'd0, 32'h0065_0000, 8'h44);
    add_particle(psu_pkg::KIND_EXPLODE, 22'd0, 22'd0, 22'd0, -22'sd3000, 22'd4000,
                 22'd5000, 12'd0, 32'h0065_0000, 8'h55);
    add_particle(psu_pkg::KIND_EXPLODE2, 22'd0, 22'd0, 22'd0, 22'd3000, -22'sd4000,
                 -22'sd5000, 12'd0, 32'h0065_0000, 8'h66);
    add_particle(psu_pkg::KIND_BLOB, 22'd100, 22'd100, 22'd100, -22'sd1234, 22'd777,
                 22'd99, 12'd50, 32'h0065_0000, 8'h77);
    add_particle(psu_pkg::KIND_BLOB2, 22'd100, 22'd100, 22'd100, -22'sd1234, 22'd777,
                 22'd99, 12'd50, 32'h0065_0000, 8'h88);
    // expired one tick ago, and expiring exactly now
    add_particle(psu_pkg::KIND_GRAV, 22'd1, 22'd2, 22'd3, 22'd4, 22'd5, 22'd6, 12'd7,
                 32'h0063_FFFF, 8'h99);
    add_particle(psu_pkg::KIND_GRAV, 22'd1, 22'd2, 22'd3, 22'd4, 22'd5, 22'd6, 12'd7,
                 32'h0064_0000, 8'h99);
    // position and velocity saturation at both ends
    add_particle(psu_pkg::KIND_STATIC, VecTop, VecTop, VecTop, VecTop, VecTop, VecTop,
                 12'hFFF, 32'hFFFF_FFFF, 8'hFF);
    add_particle(psu_pkg::KIND_GRAV, VecBottom, VecBottom, VecBottom, VecBottom,
                 VecBottom, VecBottom, 12'd0, 32'h0064_0001, 8'h00);
    // fire opacity and run-out around 6.0, and ramp overflow
    add_particle(psu_pkg::KIND_FIRE, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0,
                 12'd1536, 32'h0070_0000, 8'h01);
    add_particle(psu_pkg::KIND_FIRE, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0,
                 12'd1537, 32'h0070_0000, 8'h02);
    add_particle(psu_pkg::KIND_FIRE, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, VecTop,
                 12'd1514, 32'h0070_0000, 8'h03);
    add_particle(psu_pkg::KIND_FIRE, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0,
                 12'd1515, 32'h0070_0000, 8'h04);
    add_particle(psu_pkg::KIND_FIRE, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0,
                 12'hFFF, 32'h0070_0000, 8'h05);
    // explosion ramps around 8.0 and at the top
    add_particle(psu_pkg::KIND_EXPLODE, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0,
                 12'd2000, 32'h0070_0000, 8'h06);
    add_particle(psu_pkg::KIND_EXPLODE, 22'd0, 22'd0, 22'd0, VecBottom, VecBottom,
                 VecBottom, 12'd2047, 32'h0070_0000, 8'h07);
    add_particle(psu_pkg::KIND_EXPLODE2, 22'd0, 22'd0, 22'd0, VecTop, VecBottom,
                 VecTop, 12'hFFF, 32'h0070_0000, 8'h08);
    // growth terms pushed into saturation
    add_particle(psu_pkg::KIND_BLOB, 22'd0, 22'd0, 22'd0, VecTop, VecBottom, VecTop,
                 12'd0, 32'h0070_0000, 8'h09);
    add_particle(psu_pkg::KIND_BLOB2, 22'd0, 22'd0, 22'd0, VecBottom, VecTop,
                 VecBottom, 12'd0, 32'h0070_0000, 8'h0a);
    wait_drained();

    // Random sets, the register extremes among them
    set_clock(32'h0064_0000, 16'h0444);
    add_random(RandomPerSet);
    wait_drained();
    set_clock(32'h0000_0000, 16'hFFFF);
    add_random(RandomPerSet);
    wait_drained();
    set_clock(32'hFFFF_FFFF, 16'h0000);
    add_random(RandomPerSet);
    wait_drained();
    set_clock(32'h1234_5678, 16'h0001);
    add_random(RandomPerSet);
    wait_drained();
    set_clock($urandom, 16'($urandom));
    add_random(RandomPerSet);
    wait_drained();
    set_clock($urandom, 16'($urandom_range(16'h8000, 16'hFFFF)));
    add_random(RandomPerSet);
    wait_drained();

    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("particle_state_update test passed");
    end else begin
      $display("particle_state_update test failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("particle_state_update test failed");
    $finish;
  end

endmodule
